/* rtl/dcbr_pkg.sv */
// Shared types, constants and helpers for the capture buffer ring.
package dcbr_pkg;

    localparam int NUM_BUFS        = 4;
    localparam int BUF_BYTES       = 2048;
    localparam int IDX_W           = $clog2(NUM_BUFS);
    localparam int POS_W           = 12;
    localparam int OFF_W           = 11;
    localparam int CNT_W           = 3;
    localparam int SLOT_W          = 3;
    localparam int REQ_W           = 16;
    localparam int DMA_SLOTS_RESET = 2;

    localparam logic [POS_W-1:0]  BUF_BYTES_W  = POS_W'(BUF_BYTES);
    localparam logic [SLOT_W-1:0] SLOTS_RST_W  = SLOT_W'(DMA_SLOTS_RESET);

    // Command codes of an input word.
    localparam logic [1:0] CMD_FILL_DONE = 2'd0;
    localparam logic [1:0] CMD_GRAB      = 2'd1;
    localparam logic [1:0] CMD_RELEASE   = 2'd2;

    // Status codes of a result word.
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NO_FULL  = 2'd1;
    localparam logic [1:0] STS_BOGUS    = 2'd2;
    localparam logic [1:0] STS_NO_GRANT = 2'd3;

    typedef enum logic [1:0] {
        BUF_FREE    = 2'd0,
        BUF_FILLING = 2'd1,
        BUF_FULL    = 2'd2,
        BUF_READING = 2'd3
    } buf_state_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [REQ_W-1:0] request_bytes;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] buffer_index;
        logic [OFF_W-1:0] byte_offset;
        logic [POS_W-1:0] granted_bytes;
        logic [IDX_W-1:0] issued_first;
        logic [CNT_W-1:0] issued_count;
        logic             dma_started;
        logic             dma_halted;
        logic             buffer_freed;
    } out_word_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_STEP,
        OP_MARK_FULL,
        OP_SCAN_MISS,
        OP_GRANT,
        OP_REPORT,
        OP_RELEASE,
        OP_NO_GRANT,
        OP_ISSUE,
        OP_ISSUE_END,
        OP_PUBLISH
    } dp_op_t;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       grant_pending;
        logic       dma_active;
        logic       hit;
        logic       scan_last;
        logic       can_issue;
    } dp_status_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(NUM_BUFS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + IDX_W'(1);
        end
        return r;
    endfunction

endpackage

/* rtl/dma_capture_buffer_ring_top.sv */
// Top level of the DMA capture buffer ring controller.
//
//   Channel   Direction  Handshake           Word
//   cfg       in         cfg_valid/ready     dma_slots value (3 bits)
//   in        in         in_valid/in_stall   in_word_t: cmd, request_bytes
//   out       out        out_valid/out_stall out_word_t: status ... buffer_freed
//
// Every event word yields exactly one result word. Events are handled one at a
// time: an accepted word passes dispatch and, as its command needs, the ring
// scan (up to one buffer per cycle over all buffers) and the issue loop (one
// buffer handed to DMA per cycle) before its result enters the output register.
// The output register lets a new event be accepted while the last result is
// still stalled; a finished result waits only if the previous one is untaken.
// Reset returns all buffers to idle with zero offsets and dma_slots to 2.
module dma_capture_buffer_ring_top
    import dcbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SLOT_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_data
);

    dp_op_t     op;
    dp_status_t st;
    logic       cfg_we;

    // The slot register can be written in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // The controller walks each event through dispatch, scan and issue steps.
    dcbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .op        (op)
    );

    // The datapath holds the ring, the grant and the output register.
    dcbr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .op       (op),
        .st       (st),
        .out_data (out_data)
    );

endmodule

/* rtl/dcbr_datapath.sv */
// Ring state, scan pointer, result accumulation and output register.
module dcbr_datapath
    import dcbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SLOT_W-1:0] cfg_data,
    input  in_word_t          in_data,
    input  dp_op_t            op,
    output dp_status_t        st,
    output out_word_t         out_data
);

    buf_state_t       buf_state_reg [NUM_BUFS];
    buf_state_t       buf_state_next[NUM_BUFS];
    logic [POS_W-1:0] read_pos_reg  [NUM_BUFS];
    logic [POS_W-1:0] read_pos_next [NUM_BUFS];
    logic [IDX_W-1:0] next_fill_reg, next_fill_next;
    logic             dma_active_reg, dma_active_next;
    logic             grant_pending_reg, grant_pending_next;
    logic [IDX_W-1:0] grant_index_reg, grant_index_next;
    logic [POS_W-1:0] grant_bytes_reg, grant_bytes_next;
    logic [SLOT_W-1:0] dma_slots_reg, dma_slots_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    out_word_t        res_reg, res_next;
    out_word_t        out_reg, out_next;

    buf_state_t       cur_state;
    buf_state_t       want_state;
    logic [POS_W-1:0] cur_pos;
    logic [CNT_W-1:0] busy;
    logic [POS_W-1:0] remain;
    logic [POS_W-1:0] grant_amt;
    logic [POS_W:0]   end_sum;

    assign cur_state  = buf_state_reg[ptr_reg];
    assign cur_pos    = read_pos_reg[ptr_reg];
    assign want_state = (cmd_reg == CMD_FILL_DONE) ? BUF_FILLING : BUF_FULL;

    always_comb
    begin
        busy = '0;
        for (int i = 0; i < NUM_BUFS; i++)
        begin
            if (buf_state_reg[i] == BUF_FILLING)
            begin
                busy = busy + CNT_W'(1);
            end
        end
    end

    assign remain    = (cur_pos < BUF_BYTES_W) ? (BUF_BYTES_W - cur_pos) : '0;
    assign grant_amt = (req_reg < REQ_W'(remain)) ? req_reg[POS_W-1:0] : remain;
    assign end_sum   = {1'b0, cur_pos} + {1'b0, grant_bytes_reg};

    assign st.cmd           = cmd_reg;
    assign st.grant_pending = grant_pending_reg;
    assign st.dma_active    = dma_active_reg;
    assign st.hit           = (cur_state == want_state);
    assign st.scan_last     = (cnt_reg == IDX_W'(NUM_BUFS - 1));
    assign st.can_issue     = (cur_state == BUF_FREE) && (SLOT_W'(busy) < dma_slots_reg);

    always_comb
    begin
        buf_state_next     = buf_state_reg;
        read_pos_next      = read_pos_reg;
        next_fill_next     = next_fill_reg;
        dma_active_next    = dma_active_reg;
        grant_pending_next = grant_pending_reg;
        grant_index_next   = grant_index_reg;
        grant_bytes_next   = grant_bytes_reg;
        dma_slots_next     = cfg_we ? cfg_data : dma_slots_reg;
        cmd_next           = cmd_reg;
        req_next           = req_reg;
        ptr_next           = ptr_reg;
        cnt_next           = cnt_reg;
        res_next           = res_reg;
        out_next           = out_reg;

        unique case (op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                cmd_next = in_data.cmd;
                req_next = in_data.request_bytes;
                res_next = '0;
                cnt_next = '0;
                if (((in_data.cmd == CMD_GRAB) || (in_data.cmd == CMD_RELEASE))
                    && grant_pending_reg)
                begin
                    ptr_next = grant_index_reg;
                end
                else
                begin
                    ptr_next = next_fill_reg;
                end
            end
            OP_STEP:
            begin
                ptr_next = ring_next(ptr_reg);
                cnt_next = cnt_reg + IDX_W'(1);
            end
            OP_MARK_FULL:
            begin
                buf_state_next[ptr_reg] = BUF_FULL;
                res_next.buffer_index   = ptr_reg;
                dma_active_next         = 1'b1;
                ptr_next                = next_fill_reg;
            end
            OP_SCAN_MISS:
            begin
                res_next.status = (cmd_reg == CMD_FILL_DONE) ? STS_BOGUS : STS_NO_FULL;
                ptr_next        = next_fill_reg;
            end
            OP_GRANT:
            begin
                buf_state_next[ptr_reg] = BUF_READING;
                grant_pending_next      = 1'b1;
                grant_index_next        = ptr_reg;
                grant_bytes_next        = grant_amt;
                res_next.buffer_index   = ptr_reg;
                res_next.byte_offset    = cur_pos[OFF_W-1:0];
                res_next.granted_bytes  = grant_amt;
            end
            OP_REPORT:
            begin
                res_next.buffer_index  = ptr_reg;
                res_next.byte_offset   = cur_pos[OFF_W-1:0];
                res_next.granted_bytes = grant_bytes_reg;
            end
            OP_RELEASE:
            begin
                res_next.buffer_index  = ptr_reg;
                res_next.granted_bytes = grant_bytes_reg;
                if (end_sum >= (POS_W + 1)'(BUF_BYTES))
                begin
                    buf_state_next[ptr_reg] = BUF_FREE;
                    read_pos_next[ptr_reg]  = '0;
                    res_next.buffer_freed   = 1'b1;
                end
                else
                begin
                    buf_state_next[ptr_reg] = BUF_FULL;
                    read_pos_next[ptr_reg]  = end_sum[POS_W-1:0];
                end
                grant_pending_next = 1'b0;
            end
            OP_NO_GRANT:
            begin
                res_next.status = STS_NO_GRANT;
            end
            OP_ISSUE:
            begin
                buf_state_next[ptr_reg] = BUF_FILLING;
                read_pos_next[ptr_reg]  = '0;
                if (res_reg.issued_count == '0)
                begin
                    res_next.issued_first = ptr_reg;
                end
                res_next.issued_count = res_reg.issued_count + CNT_W'(1);
                ptr_next              = ring_next(ptr_reg);
                next_fill_next        = ring_next(ptr_reg);
            end
            OP_ISSUE_END:
            begin
                if (cmd_reg == CMD_FILL_DONE)
                begin
                    if (res_reg.issued_count == '0)
                    begin
                        dma_active_next     = 1'b0;
                        res_next.dma_halted = 1'b1;
                        for (int i = 0; i < NUM_BUFS; i++)
                        begin
                            if (buf_state_reg[i] != BUF_READING)
                            begin
                                buf_state_next[i] = BUF_FREE;
                            end
                        end
                    end
                end
                else if (res_reg.issued_count != '0)
                begin
                    dma_active_next      = 1'b1;
                    res_next.dma_started = 1'b1;
                end
            end
            OP_PUBLISH:
            begin
                out_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFS; i++)
            begin
                buf_state_reg[i] <= BUF_FREE;
                read_pos_reg[i]  <= '0;
            end
            next_fill_reg     <= '0;
            dma_active_reg    <= 1'b0;
            grant_pending_reg <= 1'b0;
            grant_index_reg   <= '0;
            grant_bytes_reg   <= '0;
            dma_slots_reg     <= SLOTS_RST_W;
            cmd_reg           <= '0;
            ptr_reg           <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            buf_state_reg     <= buf_state_next;
            read_pos_reg      <= read_pos_next;
            next_fill_reg     <= next_fill_next;
            dma_active_reg    <= dma_active_next;
            grant_pending_reg <= grant_pending_next;
            grant_index_reg   <= grant_index_next;
            grant_bytes_reg   <= grant_bytes_next;
            dma_slots_reg     <= dma_slots_next;
            cmd_reg           <= cmd_next;
            ptr_reg           <= ptr_next;
            cnt_reg           <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

/* rtl/dcbr_ctrl.sv */
// Sequencing state machine for the capture buffer ring.
module dcbr_ctrl
    import dcbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t st,
    output dp_op_t     op
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_SCAN     = 5'b00100,
        S_ISSUE    = 5'b01000,
        S_DONE     = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NONE;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (st.cmd)
                    CMD_FILL_DONE:
                    begin
                        state_next = S_SCAN;
                    end
                    CMD_GRAB:
                    begin
                        if (st.grant_pending)
                        begin
                            op         = OP_REPORT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        op         = st.grant_pending ? OP_RELEASE : OP_NO_GRANT;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (st.hit)
                begin
                    if (st.cmd == CMD_FILL_DONE)
                    begin
                        op         = OP_MARK_FULL;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        op         = OP_GRANT;
                        state_next = S_DONE;
                    end
                end
                else if (st.scan_last)
                begin
                    op = OP_SCAN_MISS;
                    if ((st.cmd == CMD_GRAB) && !st.dma_active)
                    begin
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    op = OP_STEP;
                end
            end
            S_ISSUE:
            begin
                if (st.can_issue)
                begin
                    op = OP_ISSUE;
                end
                else
                begin
                    op         = OP_ISSUE_END;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    op             = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sim/dma_capture_buffer_ring_top_tb.sv */
// Self-checking testbench for the DMA capture buffer ring controller.
`timescale 1ns / 100ps

module dma_capture_buffer_ring_top_tb;
    import dcbr_pkg::*;

    // The input word can carry a fourth command code that the block must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Mismatch lines beyond this count are counted but not printed.
    localparam int MAX_REPORTS = 40;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [SLOT_W-1:0] cfg_data   = '0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    in_word_t          in_data    = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    out_word_t         out_data;

    // Idling control, changed between traffic phases (percent of cycles).
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Shadow copy of the ring as the block should see it after each accepted word.
    buf_state_t        ring_state [NUM_BUFS];
    logic [POS_W-1:0]  rd_offset  [NUM_BUFS];
    int                fill_ptr   = 0;
    bit                dma_on     = 1'b0;
    bit                grant_open = 1'b0;
    int                grant_buf  = 0;
    int                grant_len  = 0;
    int                slots_cfg  = DMA_SLOTS_RESET;

    // Results predicted for accepted words, oldest first.
    out_word_t pending_results [$];

    int err_cnt    = 0;
    int n_events   = 0;
    int n_results  = 0;
    int n_halts    = 0;
    int n_frees    = 0;
    int n_starts   = 0;

    dma_capture_buffer_ring_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run must never take this long, even with heavy idling on both sides.
    initial
    begin
        #5_000_000;
        $display("dma_capture_buffer_ring_top_tb: errors");
        $finish;
    end

    // The receiver stalls at random; the percentage follows the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Ring predictor
    // ------------------------------------------------------------------

    // Oldest buffer in the wanted state, searching the whole ring from the
    // fill pointer; NUM_BUFS when there is none.
    function automatic int oldest_in(input buf_state_t want);
        int i;
        i = fill_ptr;
        for (int n = 0; n < NUM_BUFS; n++)
        begin
            if (ring_state[i] == want)
            begin
                return i;
            end
            i = (i + 1) % NUM_BUFS;
        end
        return NUM_BUFS;
    endfunction

    // Hand idle buffers to the DMA in ring order while slots remain.
    function automatic void hand_to_dma(output int first, output int cnt);
        int busy;
        busy  = 0;
        first = 0;
        cnt   = 0;
        for (int n = 0; n < NUM_BUFS; n++)
        begin
            if (ring_state[n] == BUF_FILLING)
            begin
                busy++;
            end
        end
        while (ring_state[fill_ptr] == BUF_FREE && busy < slots_cfg)
        begin
            if (cnt == 0)
            begin
                first = fill_ptr;
            end
            ring_state[fill_ptr] = BUF_FILLING;
            rd_offset[fill_ptr]  = '0;
            fill_ptr = (fill_ptr + 1) % NUM_BUFS;
            busy++;
            cnt++;
        end
    endfunction

    // Apply one event word to the shadow ring and return the result word.
    function automatic out_word_t predict_ring_event(input in_word_t w);
        out_word_t r;
        int        b;
        int        first;
        int        cnt;
        int        rem;
        int        grant;
        int        last;
        r = '0;
        case (w.cmd)
            CMD_FILL_DONE:
            begin
                b = oldest_in(BUF_FILLING);
                if (b == NUM_BUFS)
                begin
                    // Completion with nothing on the DMA: no state change.
                    r.status = STS_BOGUS;
                end
                else
                begin
                    ring_state[b]  = BUF_FULL;
                    r.buffer_index = IDX_W'(b);
                    dma_on = 1'b1;
                    hand_to_dma(first, cnt);
                    r.issued_first = IDX_W'(first);
                    r.issued_count = CNT_W'(cnt);
                    if (cnt == 0)
                    begin
                        // Overrun: the DMA stops and everything not being
                        // read is thrown back to idle.
                        dma_on = 1'b0;
                        r.dma_halted = 1'b1;
                        for (int n = 0; n < NUM_BUFS; n++)
                        begin
                            if (ring_state[n] != BUF_READING)
                            begin
                                ring_state[n] = BUF_FREE;
                            end
                        end
                    end
                end
            end
            CMD_GRAB:
            begin
                if (grant_open)
                begin
                    // A second grab just repeats the outstanding grant.
                    r.buffer_index  = IDX_W'(grant_buf);
                    r.byte_offset   = rd_offset[grant_buf][OFF_W-1:0];
                    r.granted_bytes = POS_W'(grant_len);
                end
                else
                begin
                    b = oldest_in(BUF_FULL);
                    if (b == NUM_BUFS)
                    begin
                        r.status = STS_NO_FULL;
                        if (!dma_on)
                        begin
                            hand_to_dma(first, cnt);
                            r.issued_first = IDX_W'(first);
                            r.issued_count = CNT_W'(cnt);
                            if (cnt != 0)
                            begin
                                dma_on = 1'b1;
                                r.dma_started = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        rem   = BUF_BYTES - int'(rd_offset[b]);
                        grant = (int'(w.request_bytes) < rem) ? int'(w.request_bytes) : rem;
                        ring_state[b]   = BUF_READING;
                        grant_open      = 1'b1;
                        grant_buf       = b;
                        grant_len       = grant;
                        r.buffer_index  = IDX_W'(b);
                        r.byte_offset   = rd_offset[b][OFF_W-1:0];
                        r.granted_bytes = POS_W'(grant);
                    end
                end
            end
            CMD_RELEASE:
            begin
                if (!grant_open)
                begin
                    r.status = STS_NO_GRANT;
                end
                else
                begin
                    last = int'(rd_offset[grant_buf]) + grant_len;
                    r.buffer_index  = IDX_W'(grant_buf);
                    r.granted_bytes = POS_W'(grant_len);
                    if (last >= BUF_BYTES)
                    begin
                        ring_state[grant_buf] = BUF_FREE;
                        rd_offset[grant_buf]  = '0;
                        r.buffer_freed = 1'b1;
                    end
                    else
                    begin
                        // Partly read: the buffer goes back to full with the
                        // offset moved past the bytes consumed.
                        ring_state[grant_buf] = BUF_FULL;
                        rd_offset[grant_buf]  = POS_W'(last);
                    end
                    grant_open = 1'b0;
                end
            end
            default:
            begin
                // The unused command leaves the ring alone and answers zeros.
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one event word, with a random gap in front of it when the phase
    // asks for sender idling. The expected result is queued on acceptance.
    task automatic send_event(input logic [1:0] cmd, input logic [REQ_W-1:0] req);
        in_word_t w;
        w.cmd           = cmd;
        w.request_bytes = req;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_results.push_back(predict_ring_event(w));
        n_events++;
    endtask

    // Stop sending and let every expected word come out, then let the
    // block sit idle before anything else happens.
    task automatic drain_ring;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    // Write dma_slots; only called while the block is idle.
    task automatic set_dma_slots(input int slots);
        cfg_valid <= 1'b1;
        cfg_data  <= SLOT_W'(slots);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        slots_cfg = slots;
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            if (err_cnt < MAX_REPORTS)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
            err_cnt++;
        end
    endtask

    // Every word taken from the output is compared with the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin : check_results
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (err_cnt < MAX_REPORTS)
                begin
                    $display("%0t: result word expected none, got %h", $time, out_data);
                end
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(out_data.status));
                check_field("buffer_index", 16'(want.buffer_index),
                            16'(out_data.buffer_index));
                check_field("byte_offset", 16'(want.byte_offset),
                            16'(out_data.byte_offset));
                check_field("granted_bytes", 16'(want.granted_bytes),
                            16'(out_data.granted_bytes));
                check_field("issued_first", 16'(want.issued_first),
                            16'(out_data.issued_first));
                check_field("issued_count", 16'(want.issued_count),
                            16'(out_data.issued_count));
                check_field("dma_started", 16'(want.dma_started),
                            16'(out_data.dma_started));
                check_field("dma_halted", 16'(want.dma_halted),
                            16'(out_data.dma_halted));
                check_field("buffer_freed", 16'(want.buffer_freed),
                            16'(out_data.buffer_freed));
                n_results++;
                n_halts  += int'(want.dma_halted);
                n_frees  += int'(want.buffer_freed);
                n_starts += int'(want.dma_started);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk the ring through its corner cases at the reset slot count: bogus
    // completion, release with no grant, the unused command, DMA start from
    // a grab, zero-byte grant, repeated grab, partial and complete release,
    // and an overrun that halts the DMA and flushes the ring.
    task automatic test_event_corners;
        send_event(CMD_FILL_DONE, '0);
        send_event(CMD_RELEASE, '0);
        send_event(CMD_UNUSED, 16'hFFFF);
        send_event(CMD_GRAB, 16'd0);
        send_event(CMD_GRAB, 16'd5);
        send_event(CMD_FILL_DONE, '0);
        send_event(CMD_GRAB, 16'd0);
        send_event(CMD_GRAB, 16'd123);
        send_event(CMD_RELEASE, '0);
        send_event(CMD_GRAB, 16'd100);
        send_event(CMD_RELEASE, '0);
        send_event(CMD_GRAB, 16'hFFFF);
        send_event(CMD_GRAB, 16'd7);
        send_event(CMD_FILL_DONE, '0);
        send_event(CMD_FILL_DONE, '0);
        send_event(CMD_RELEASE, '0);
        send_event(CMD_GRAB, 16'hAAAA);
        send_event(CMD_FILL_DONE, '0);
        send_event(CMD_GRAB, 16'h5555);
        send_event(CMD_RELEASE, '0);
        drain_ring();
    endtask

    // The slot register at its extremes: with zero slots nothing is ever
    // issued, so a completion halts and a grab cannot restart the DMA; with
    // seven the whole ring goes to the DMA at once.
    task automatic test_slot_limits;
        set_dma_slots(0);
        send_event(CMD_FILL_DONE, '0);
        send_event(CMD_GRAB, 16'd1);
        send_event(CMD_GRAB, 16'd2);
        drain_ring();
        set_dma_slots(7);
        send_event(CMD_GRAB, 16'd1);
        send_event(CMD_FILL_DONE, '0);
        send_event(CMD_GRAB, 16'd2048);
        drain_ring();
        set_dma_slots(4);
        send_event(CMD_GRAB, 16'd3);
        send_event(CMD_FILL_DONE, '0);
        send_event(CMD_RELEASE, '0);
        drain_ring();
    endtask

    // Random traffic with one slot setting and one idling mode. Most words
    // follow the natural reader pattern: a grab is usually followed by its
    // release, completions keep the ring turning, and some noise is mixed in.
    task automatic test_traffic_mix(input int slots, input int send_pct,
                                    input int stall_p, input int count);
        logic [1:0]       cmd;
        logic [REQ_W-1:0] req;
        int               pick;
        set_dma_slots(slots);
        send_idle_pct = send_pct;
        stall_pct     = stall_p;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (grant_open)
            begin
                cmd = (pick < 60) ? CMD_RELEASE : (pick < 80) ? CMD_FILL_DONE : CMD_GRAB;
            end
            else
            begin
                cmd = (pick < 45) ? CMD_FILL_DONE : (pick < 90) ? CMD_GRAB :
                      (pick < 95) ? CMD_RELEASE : CMD_UNUSED;
            end
            case ($urandom_range(0, 4))
                0:       req = '0;
                1:       req = REQ_W'($urandom_range(1, 256));
                2:       req = REQ_W'($urandom_range(1024, 2048));
                3:       req = REQ_W'($urandom);
                default: req = '1;
            endcase
            send_event(cmd, req);
        end
        drain_ring();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial
    begin
        for (int n = 0; n < NUM_BUFS; n++)
        begin
            ring_state[n] = BUF_FREE;
            rd_offset[n]  = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_event_corners();
        test_slot_limits();
        // Slot settings vary from 0 to 7 while the idling mode
        // cycles through none, sender gaps, receiver stalls and light both.
        test_traffic_mix(2, 0, 0, 80);
        test_traffic_mix(1, 70, 0, 75);
        test_traffic_mix(4, 0, 70, 80);
        test_traffic_mix(7, 8, 8, 80);
        test_traffic_mix(3, 0, 0, 80);
        test_traffic_mix(0, 70, 0, 30);
        test_traffic_mix(4, 0, 70, 80);
        test_traffic_mix(1, 8, 8, 80);
        test_traffic_mix(5, 0, 0, 40);

        $display("Sent %0d event words over slot counts 0 to 7 and four idling modes;",
                 n_events);
        $display("checked %0d results, %0d DMA starts, %0d halts, %0d buffers freed.",
                 n_results, n_starts, n_halts, n_frees);
        if (err_cnt == 0)
        begin
            $display("dma_capture_buffer_ring_top_tb: clean");
        end
        else
        begin
            $display("dma_capture_buffer_ring_top_tb: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/dcbr_pkg.sv
rtl/dcbr_datapath.sv
rtl/dcbr_ctrl.sv
rtl/dma_capture_buffer_ring_top.sv
sim/dma_capture_buffer_ring_top_tb.sv
